FILE: rtl/lsb_pkg.sv
// Shared types, constants and sine table function for the LFO sine bank.
`timescale 1ns / 1ps
package lsb_pkg;

  localparam int REQ_W    = 2;
  localparam int CHAN_W   = 5;
  localparam int FREQ_W   = 19;
  localparam int DELTA_W  = 10;
  localparam int PHASE_W  = 32;
  localparam int VALUE_W  = 16;
  localparam int SINE_W   = 15;

  localparam int DIGIT_W  = 5;
  localparam int NARROW_W = 13;
  localparam int NDIG     = (NARROW_W + DIGIT_W - 1) / DIGIT_W;
  localparam int CNT_W    = 2;

  localparam logic [REQ_W-1:0] REQ_TICK   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_CREATE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd2;
  localparam logic [REQ_W-1:0] REQ_FREQ   = 2'd3;

  localparam logic [NARROW_W-1:0] STEP_PER_MHZ = 13'd4295;
  localparam logic [PHASE_W-1:0]  DEFAULT_STEP = 32'd429500;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned ONE_Q30     = 64'd1 << 30;

  typedef struct packed {
    logic                start;
    logic [PHASE_W-1:0]  base;
    logic [PHASE_W-1:0]  mult;
    logic [NARROW_W-1:0] narrow;
  } mac_req_t;

  function automatic logic [SINE_W-1:0] sine_entry(input int unsigned i,
                                                   input int unsigned abits);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    longint unsigned s;
    longint unsigned v;
    x    = (HALF_PI_Q30 * longint'(i) + (64'd1 << (abits - 1))) >> abits;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    term = ((term * x2) >> 30) / 6;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 20;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 42;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 72;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 110;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 156;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 210;
    sum  = sum - longint'(term);
    if (sum < 0) begin
      sum = 0;
    end
    s = longint'(sum);
    if (s > ONE_Q30) begin
      s = ONE_Q30;
    end
    v = (s * 64'd32767 + (ONE_Q30 >> 1)) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return v[SINE_W-1:0];
  endfunction

endpackage

FILE: rtl/lsb_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module lsb_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/lsb_mac.sv
// Digit-serial multiply-accumulate: base + mult * narrow, five multiplier bits per cycle.
`timescale 1ns / 1ps
module lsb_mac (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lsb_pkg::mac_req_t             req_i,
  output logic                          done_o,
  output logic [lsb_pkg::PHASE_W-1:0]   acc_o
);

  logic [lsb_pkg::PHASE_W-1:0]  acc_q, acc_d;
  logic [lsb_pkg::PHASE_W-1:0]  mult_q, mult_d;
  logic [lsb_pkg::NARROW_W-1:0] dig_q, dig_d;
  logic [lsb_pkg::CNT_W-1:0]    cnt_q, cnt_d;
  logic                         busy_q, busy_d;
  logic                         done_q, done_d;

  always_comb begin
    acc_d  = acc_q;
    mult_d = mult_q;
    dig_d  = dig_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      acc_d  = req_i.base;
      mult_d = req_i.mult;
      dig_d  = req_i.narrow;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      acc_d  = acc_q + lsb_pkg::PHASE_W'(mult_q * dig_q[lsb_pkg::DIGIT_W-1:0]);
      mult_d = mult_q << lsb_pkg::DIGIT_W;
      dig_d  = dig_q >> lsb_pkg::DIGIT_W;
      if (cnt_q == lsb_pkg::CNT_W'(lsb_pkg::NDIG - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q + lsb_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    mult_q <= mult_d;
    dig_q  <= dig_d;
  end

  assign done_o = done_q;
  assign acc_o  = acc_q;

endmodule

FILE: rtl/lsb_sine.sv
// Quarter-wave sine lookup with quadrant folding and registered table read.
`timescale 1ns / 1ps
module lsb_sine #(
  parameter int ADDR_BITS = 10
) (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic [lsb_pkg::PHASE_W-1:0]         phase_i,
  output logic signed [lsb_pkg::VALUE_W-1:0]  value_o
);

  localparam int N = 1 << ADDR_BITS;

  logic [lsb_pkg::SINE_W-1:0] rom [N + 1];
  logic [ADDR_BITS-1:0]       idx;
  logic [ADDR_BITS:0]         addr;
  logic [1:0]                 quad;
  logic [lsb_pkg::SINE_W-1:0] mag_q;
  logic                       neg_q;
  logic [lsb_pkg::VALUE_W-1:0] mag_ext;

  for (genvar i = 0; i <= N; i++) begin : g_rom
    assign rom[i] = lsb_pkg::sine_entry(i, ADDR_BITS);
  end

  assign quad = phase_i[lsb_pkg::PHASE_W-1 -: 2];
  assign idx  = phase_i[lsb_pkg::PHASE_W-3 -: ADDR_BITS];
  assign addr = quad[0] ? ((ADDR_BITS + 1)'(N) - {1'b0, idx}) : {1'b0, idx};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q <= rom[addr];
      neg_q <= quad[1];
    end
  end

  assign mag_ext = {1'b0, mag_q};
  assign value_o = signed'(neg_q ? (lsb_pkg::VALUE_W'(0) - mag_ext) : mag_ext);

endmodule

FILE: rtl/lfo_sine_bank_top.sv
// Top level of the LFO sine bank: request decode, channel sequencer and result register.
// Create and remove complete in the idle state; set frequency runs the 3-digit serial MAC, then writes.
// A tick scans the channels in order; each active channel goes through a RAM read,
// the three-digit MAC, a table read and a result hand-off.
// Results wait in an output register; the sequencer holds while that register is stalled.
// Reset clears the active flags and control; phase and step RAM contents are not cleared.
`timescale 1ns / 1ps
module lfo_sine_bank_top #(
  parameter int VOICES         = 16,
  parameter int SINE_ADDR_BITS = 10
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [lsb_pkg::REQ_W-1:0]          req_type_i,
  input  logic [lsb_pkg::CHAN_W-1:0]         channel_i,
  input  logic [lsb_pkg::FREQ_W-1:0]         freq_mhz_i,
  input  logic [lsb_pkg::DELTA_W-1:0]        delta_ms_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [lsb_pkg::CHAN_W-1:0]         out_channel_o,
  output logic signed [lsb_pkg::VALUE_W-1:0] sine_value_o,
  output logic                               last_o
);

  localparam int IDX_W  = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int WORD_W = 2 * lsb_pkg::PHASE_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_MAC  = 3'd3;
  localparam logic [2:0] S_SIN  = 3'd4;
  localparam logic [2:0] S_FREQ = 3'd5;

  logic [2:0]                      state_q, state_d;
  logic [IDX_W-1:0]                idx_q, idx_d;
  logic [VOICES-1:0]               active_q, active_d;
  logic [lsb_pkg::DELTA_W-1:0]     delta_q;
  logic                            out_valid_q;
  logic [lsb_pkg::CHAN_W-1:0]      out_channel_q;
  logic signed [lsb_pkg::VALUE_W-1:0] sine_q;
  logic                            last_q;

  logic                            accept;
  logic                            ch_ok;
  logic [7:0]                      ch_ext;
  logic [IDX_W-1:0]                ch_idx;
  logic                            tick_go, create_ok, remove_ok, freq_ok;
  logic                            idx_last, no_higher, out_free, out_load;

  logic                            ram_we, ram_re;
  logic [IDX_W-1:0]                ram_waddr;
  logic [WORD_W-1:0]               ram_wdata, ram_rdata;

  lsb_pkg::mac_req_t               mac_req;
  logic                            mac_done;
  logic [lsb_pkg::PHASE_W-1:0]     mac_acc;

  logic                            sin_en;
  logic signed [lsb_pkg::VALUE_W-1:0] sin_value;

  assign accept    = in_valid_i && !in_stall_o;
  assign ch_ext    = {3'b000, channel_i} - 8'd1;
  assign ch_idx    = ch_ext[IDX_W-1:0];
  assign ch_ok     = (channel_i != '0) && ({3'b000, channel_i} <= 8'(VOICES));
  assign tick_go   = accept && (req_type_i == lsb_pkg::REQ_TICK);
  assign create_ok = accept && (req_type_i == lsb_pkg::REQ_CREATE) && ch_ok
                     && !active_q[ch_idx];
  assign remove_ok = accept && (req_type_i == lsb_pkg::REQ_REMOVE) && ch_ok;
  assign freq_ok   = accept && (req_type_i == lsb_pkg::REQ_FREQ) && ch_ok
                     && (freq_mhz_i != '0) && active_q[ch_idx];

  assign idx_last  = (idx_q == IDX_W'(VOICES - 1));
  assign out_free  = !out_valid_q || !out_stall_i;

  always_comb begin
    no_higher = 1'b1;
    for (int j = 0; j < VOICES; j++) begin
      if (active_q[j] && (8'(j) > 8'(idx_q))) begin
        no_higher = 1'b0;
      end
    end
  end

  always_comb begin
    mac_req.start  = freq_ok || (state_q == S_RD);
    mac_req.base   = (state_q == S_RD) ? ram_rdata[lsb_pkg::PHASE_W-1:0] : '0;
    mac_req.mult   = (state_q == S_RD) ? ram_rdata[WORD_W-1:lsb_pkg::PHASE_W]
                                       : lsb_pkg::PHASE_W'(freq_mhz_i);
    mac_req.narrow = (state_q == S_RD) ? lsb_pkg::NARROW_W'(delta_q)
                                       : lsb_pkg::STEP_PER_MHZ;
  end

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    active_d  = active_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = idx_q;
    ram_wdata = '0;
    sin_en    = 1'b0;
    out_load  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (tick_go) begin
          state_d = S_SCAN;
          idx_d   = '0;
        end else if (freq_ok) begin
          state_d = S_FREQ;
          idx_d   = ch_idx;
        end
        if (create_ok) begin
          active_d[ch_idx] = 1'b1;
          ram_we           = 1'b1;
          ram_waddr        = ch_idx;
          ram_wdata        = {lsb_pkg::DEFAULT_STEP, lsb_pkg::PHASE_W'(0)};
        end
        if (remove_ok) begin
          active_d[ch_idx] = 1'b0;
        end
      end
      S_SCAN: begin
        if (active_q[idx_q]) begin
          ram_re  = 1'b1;
          state_d = S_RD;
        end else if (idx_last) begin
          state_d = S_IDLE;
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end
      S_RD: begin
        state_d = S_MAC;
      end
      S_MAC: begin
        if (mac_done) begin
          ram_we    = 1'b1;
          ram_wdata = {ram_rdata[WORD_W-1:lsb_pkg::PHASE_W], mac_acc};
          sin_en    = 1'b1;
          state_d   = S_SIN;
        end
      end
      S_SIN: begin
        if (out_free) begin
          out_load = 1'b1;
          if (no_higher) begin
            state_d = S_IDLE;
          end else begin
            idx_d   = idx_q + IDX_W'(1);
            state_d = S_SCAN;
          end
        end
      end
      S_FREQ: begin
        if (mac_done) begin
          ram_we    = 1'b1;
          ram_wdata = {mac_acc, lsb_pkg::PHASE_W'(0)};
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      active_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      active_q <= active_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_go) begin
      delta_q <= delta_ms_i;
    end
    if (out_load) begin
      out_channel_q <= lsb_pkg::CHAN_W'(8'(idx_q) + 8'd1);
      sine_q        <= sin_value;
      last_q        <= no_higher;
    end
  end

  lsb_ram #(
    .WIDTH (WORD_W),
    .DEPTH (VOICES)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  lsb_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mac_req),
    .done_o (mac_done),
    .acc_o  (mac_acc)
  );

  lsb_sine #(
    .ADDR_BITS (SINE_ADDR_BITS)
  ) u_sine (
    .clk_i   (clk_i),
    .en_i    (sin_en),
    .phase_i (mac_acc),
    .value_o (sin_value)
  );

  assign in_stall_o    = (state_q != S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign out_channel_o = out_channel_q;
  assign sine_value_o  = sine_q;
  assign last_o        = last_q;

  a_mac_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mac_done |-> (state_q == S_MAC || state_q == S_FREQ))
    else $error("MAC finished outside a MAC wait state");

  a_sine_to_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sin_en |=> (state_q == S_SIN))
    else $error("sine lookup not followed by result hand-off");

  a_report_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> active_q[idx_q])
    else $error("result loaded for an inactive channel");

endmodule

FILE: bench/tb_lfo_sine_bank_top.sv
// Self-checking testbench for the LFO sine bank: directed and random requests, predicted sine results.
`timescale 1ns / 1ps
module tb_lfo_sine_bank_top;

  localparam int VOICES         = 16;
  localparam int SINE_ADDR_BITS = 10;
  localparam int SINE_N         = 1 << SINE_ADDR_BITS;
  localparam int HOLD_CYCLES    = 400;
  localparam int STALL_LIMIT    = 4000;
  localparam int DRAIN_CYCLES   = 150;
  localparam int RANDOM_PER_PHASE = 50;

  localparam longint unsigned HALF_PI_Q30  = 64'd1686629713;
  localparam longint unsigned ONE_Q30      = 64'd1 << 30;
  localparam logic [31:0]     STEP_PER_MHZ = 32'd4295;
  localparam logic [31:0]     DEFAULT_STEP = 32'd100 * 32'd4295;

  typedef struct {
    logic [lsb_pkg::CHAN_W-1:0]         chan;
    logic signed [lsb_pkg::VALUE_W-1:0] value;
    logic                               last;
  } sine_result_t;

  class lfo_bank_tracker;
    bit                         active [VOICES];
    bit [31:0]                  phase  [VOICES];
    bit [31:0]                  step   [VOICES];
    bit [lsb_pkg::SINE_W-1:0]   quarter_wave [SINE_N + 1];
    sine_result_t               pending_sines [$];
    int                         errors;

    function new();
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint unsigned s;
      longint unsigned v;
      longint          sum;
      errors = 0;
      for (int c = 0; c < VOICES; c++) begin
        active[c] = 1'b0;
        phase[c]  = '0;
        step[c]   = '0;
      end
      for (int i = 0; i <= SINE_N; i++) begin
        x    = (HALF_PI_Q30 * 64'(i) + 64'(SINE_N / 2)) >> SINE_ADDR_BITS;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        for (int k = 1; k <= 7; k++) begin
          term = (term * x2) >> 30;
          term = term / 64'((2 * k) * (2 * k + 1));
          if (k % 2 == 1) begin
            sum = sum - longint'(term);
          end else begin
            sum = sum + longint'(term);
          end
        end
        if (sum < 0) begin
          sum = 0;
        end
        s = longint'(sum);
        if (s > ONE_Q30) begin
          s = ONE_Q30;
        end
        v = (s * 64'd32767 + (ONE_Q30 >> 1)) >> 30;
        if (v > 64'd32767) begin
          v = 64'd32767;
        end
        quarter_wave[i] = v[lsb_pkg::SINE_W-1:0];
      end
    endfunction

    function logic signed [15:0] sine_at(bit [31:0] ph);
      bit [1:0]                quad;
      bit [SINE_ADDR_BITS-1:0] idx;
      bit [15:0]               mag;
      quad = ph[31:30];
      idx  = ph[29 -: SINE_ADDR_BITS];
      if (quad[0]) begin
        mag = 16'(quarter_wave[SINE_N - int'(idx)]);
      end else begin
        mag = 16'(quarter_wave[int'(idx)]);
      end
      if (quad[1]) begin
        return 16'(16'd0 - mag);
      end
      return mag;
    endfunction

    function void apply_request(logic [lsb_pkg::REQ_W-1:0]   req,
                                logic [lsb_pkg::CHAN_W-1:0]  chan,
                                logic [lsb_pkg::FREQ_W-1:0]  freq,
                                logic [lsb_pkg::DELTA_W-1:0] delta);
      int           c;
      int           last_c;
      sine_result_t r;
      if (req == lsb_pkg::REQ_TICK) begin
        last_c = -1;
        for (c = 0; c < VOICES; c++) begin
          if (active[c]) begin
            last_c = c;
          end
        end
        for (c = 0; c < VOICES; c++) begin
          if (active[c]) begin
            phase[c] = phase[c] + 32'(delta) * step[c];
            r.chan   = 5'(c + 1);
            r.value  = sine_at(phase[c]);
            r.last   = (c == last_c);
            pending_sines.insert(pending_sines.size(), r);
          end
        end
        return;
      end
      if (chan == 0 || chan > VOICES) begin
        return;
      end
      c = int'(chan) - 1;
      case (req)
        lsb_pkg::REQ_CREATE: begin
          if (!active[c]) begin
            active[c] = 1'b1;
            step[c]   = DEFAULT_STEP;
            phase[c]  = '0;
          end
        end
        lsb_pkg::REQ_REMOVE: begin
          active[c] = 1'b0;
        end
        lsb_pkg::REQ_FREQ: begin
          if (freq != 0 && active[c]) begin
            step[c]  = 32'(freq) * STEP_PER_MHZ;
            phase[c] = '0;
          end
        end
        default: begin
        end
      endcase
    endfunction

    function void check_sine(logic [lsb_pkg::CHAN_W-1:0]         chan,
                             logic signed [lsb_pkg::VALUE_W-1:0] value,
                             logic                               last);
      sine_result_t e;
      if (pending_sines.size() == 0) begin
        $display("%0t: unexpected result: channel %0d value %0d last %0b",
                 $time, chan, value, last);
        errors++;
        return;
      end
      e = pending_sines.pop_front();
      if (chan !== e.chan) begin
        $display("%0t: channel mismatch: expected %0d actual %0d", $time, e.chan, chan);
        errors++;
      end
      if (value !== e.value) begin
        $display("%0t: sine mismatch on channel %0d: expected %0d actual %0d",
                 $time, e.chan, e.value, value);
        errors++;
      end
      if (last !== e.last) begin
        $display("%0t: last mismatch on channel %0d: expected %0b actual %0b",
                 $time, e.chan, e.last, last);
        errors++;
      end
    endfunction

    function int pending();
      return pending_sines.size();
    endfunction
  endclass

  logic                               clk_i       = 1'b0;
  logic                               rst_ni      = 1'b0;
  logic                               in_valid_i  = 1'b0;
  logic                               in_stall_o;
  logic [lsb_pkg::REQ_W-1:0]          req_type_i  = lsb_pkg::REQ_TICK;
  logic [lsb_pkg::CHAN_W-1:0]         channel_i   = '0;
  logic [lsb_pkg::FREQ_W-1:0]         freq_mhz_i  = '0;
  logic [lsb_pkg::DELTA_W-1:0]        delta_ms_i  = '0;
  logic                               out_valid_o;
  logic                               out_stall_i = 1'b0;
  logic [lsb_pkg::CHAN_W-1:0]         out_channel_o;
  logic signed [lsb_pkg::VALUE_W-1:0] sine_value_o;
  logic                               last_o;

  lfo_bank_tracker tracker;
  int tx_idle_pct  = 35;
  int rx_stall_pct = 64;
  bit hold_req     = 1'b0;
  bit hold_done    = 1'b0;
  int hold_left    = 0;
  int quiet_cycles = 0;

  lfo_sine_bank_top #(
    .VOICES         (VOICES),
    .SINE_ADDR_BITS (SINE_ADDR_BITS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .req_type_i    (req_type_i),
    .channel_i     (channel_i),
    .freq_mhz_i    (freq_mhz_i),
    .delta_ms_i    (delta_ms_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_channel_o (out_channel_o),
    .sine_value_o  (sine_value_o),
    .last_o        (last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (hold_req && !hold_done) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      tracker.check_sine(out_channel_o, sine_value_o, last_o);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: timeout, nothing accepted for %0d cycles", $time, STALL_LIMIT);
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_req(logic [lsb_pkg::REQ_W-1:0]   req,
                          logic [lsb_pkg::CHAN_W-1:0]  chan,
                          logic [lsb_pkg::FREQ_W-1:0]  freq,
                          logic [lsb_pkg::DELTA_W-1:0] delta);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= req;
    channel_i  <= chan;
    freq_mhz_i <= freq;
    delta_ms_i <= delta;
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
    tracker.apply_request(req, chan, freq, delta);
  endtask

  task automatic send_random();
    int                          pick;
    logic [lsb_pkg::REQ_W-1:0]   req;
    logic [lsb_pkg::CHAN_W-1:0]  chan;
    logic [lsb_pkg::FREQ_W-1:0]  freq;
    logic [lsb_pkg::DELTA_W-1:0] delta;
    pick = $urandom_range(99);
    if (pick < 30) begin
      req = lsb_pkg::REQ_TICK;
    end else if (pick < 55) begin
      req = lsb_pkg::REQ_CREATE;
    end else if (pick < 65) begin
      req = lsb_pkg::REQ_REMOVE;
    end else begin
      req = lsb_pkg::REQ_FREQ;
    end
    if ($urandom_range(99) < 85) begin
      chan = 5'($urandom_range(1, VOICES));
    end else begin
      chan = 5'($urandom_range(0, 31));
    end
    pick = $urandom_range(99);
    if (pick < 70) begin
      freq = 19'($urandom_range(1, 2000));
    end else if (pick < 80) begin
      freq = '0;
    end else begin
      freq = 19'($urandom);
    end
    if ($urandom_range(99) < 60) begin
      delta = 10'($urandom_range(0, 50));
    end else begin
      delta = 10'($urandom);
    end
    send_req(req, chan, freq, delta);
  endtask

  initial begin
    tracker = new();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_req(lsb_pkg::REQ_TICK,   5'd0,  19'd0,      10'd5);
    send_req(lsb_pkg::REQ_CREATE, 5'd0,  19'd0,      10'd0);
    send_req(lsb_pkg::REQ_CREATE, 5'd17, 19'd0,      10'd0);
    send_req(lsb_pkg::REQ_CREATE, 5'd31, 19'd0,      10'd0);
    send_req(lsb_pkg::REQ_FREQ,   5'd3,  19'd1000,   10'd0);
    send_req(lsb_pkg::REQ_REMOVE, 5'd7,  19'd0,      10'd0);
    send_req(lsb_pkg::REQ_CREATE, 5'd1,  19'd0,      10'd0);
    send_req(lsb_pkg::REQ_CREATE, 5'd16, 19'd0,      10'd0);
    send_req(lsb_pkg::REQ_CREATE, 5'd1,  19'd0,      10'd0);
    send_req(lsb_pkg::REQ_TICK,   5'd0,  19'd0,      10'd0);
    send_req(lsb_pkg::REQ_TICK,   5'd31, 19'h7FFFF,  10'd1023);
    send_req(lsb_pkg::REQ_FREQ,   5'd1,  19'd0,      10'd0);
    send_req(lsb_pkg::REQ_FREQ,   5'd16, 19'h7FFFF,  10'd0);
    send_req(lsb_pkg::REQ_TICK,   5'd0,  19'd0,      10'd1023);
    send_req(lsb_pkg::REQ_TICK,   5'd0,  19'd0,      10'd1023);
    send_req(lsb_pkg::REQ_REMOVE, 5'd1,  19'd0,      10'd0);
    send_req(lsb_pkg::REQ_TICK,   5'd0,  19'd0,      10'd1);
    send_req(lsb_pkg::REQ_FREQ,   5'd1,  19'd500,    10'd0);
    send_req(lsb_pkg::REQ_CREATE, 5'd1,  19'd0,      10'd0);
    send_req(lsb_pkg::REQ_TICK,   5'd0,  19'd0,      10'd250);
    send_req(lsb_pkg::REQ_REMOVE, 5'd16, 19'd0,      10'd0);
    send_req(lsb_pkg::REQ_REMOVE, 5'd1,  19'd0,      10'd0);
    send_req(lsb_pkg::REQ_TICK,   5'd0,  19'd0,      10'd1);
    send_req(lsb_pkg::REQ_CREATE, 5'd8,  19'd0,      10'd0);
    send_req(lsb_pkg::REQ_FREQ,   5'd8,  19'd1,      10'd0);
    send_req(lsb_pkg::REQ_TICK,   5'd0,  19'd0,      10'd1023);

    repeat (RANDOM_PER_PHASE) send_random();

    tx_idle_pct = 64;
    rx_stall_pct <= 35;
    repeat (RANDOM_PER_PHASE) send_random();

    tx_idle_pct = 0;
    rx_stall_pct <= 0;
    for (int c = 1; c <= VOICES; c++) begin
      send_req(lsb_pkg::REQ_CREATE, 5'(c), 19'($urandom), 10'($urandom));
    end
    hold_req <= 1'b1;
    repeat (6) begin
      send_req(lsb_pkg::REQ_TICK, 5'($urandom), 19'($urandom), 10'($urandom));
    end

    repeat (RANDOM_PER_PHASE) send_random();

    in_valid_i <= 1'b0;
    while (tracker.pending() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (tracker.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: lfo_sine_bank_top.f
rtl/lsb_pkg.sv
rtl/lsb_ram.sv
rtl/lsb_mac.sv
rtl/lsb_sine.sv
rtl/lfo_sine_bank_top.sv
bench/tb_lfo_sine_bank_top.sv
